// ===== rtl/ea2x_pkg.sv =====
// shared types and constants of the edge-aware 2x upscaler
package ea2x_pkg;

	localparam int PixW   = 8;
	localparam int ThrW   = 8;
	localparam int FwW    = 12;
	localparam int FhW    = 13;
	localparam int RowOW  = 13;
	localparam int ColOW  = 12;
	localparam int AddrW  = 4;
	localparam int SlotN  = 16;

	// register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	// anchor codes within one request
	localparam logic [1:0] ANC_UP_LEFT = 2'd0;
	localparam logic [1:0] ANC_UP      = 2'd1;
	localparam logic [1:0] ANC_LEFT    = 2'd2;
	localparam logic [1:0] ANC_SELF    = 2'd3;

	localparam logic [7:0]  THRESHOLD_RST = 8'd30;
	localparam logic [11:0] WIDTH_RST     = 12'd640;
	localparam logic [12:0] HEIGHT_RST    = 13'd480;

	typedef struct packed {
		logic [ThrW-1:0] threshold;
		logic [FwW-1:0]  width;
		logic [FhW-1:0]  height;
		logic            geom_wr;
	} cfg_t;

	typedef struct packed {
		logic [PixW-1:0] a;
		logic [PixW-1:0] b;
		logic [PixW-1:0] d;
		logic [PixW-1:0] e;
		logic            last_row;
		logic            last_col;
		logic            r_nz;
		logic            c_nz;
	} pix_t;

endpackage

// ===== rtl/edge_aware_2x_upscaler_core.sv =====
// top level of the edge-aware 2x grayscale upscaler
//
//  channel   signals                                          direction
//  pixel     in_valid/in_ready, pixel_value                   in
//  result    out_valid/out_ready, out_value, out_row,         out
//            out_col, last_of_item, frame_done
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready   apb
//
// an accepted pixel request is registered in the line memory read stage, then one
// result leaves per cycle while out_ready is high: each pixel yields the results
// of every anchor it closes, an interior pixel those of its up-left anchor only;
// the result sequencer sets the pace. reset clears counters, left pixels and
// pending results; the line memory is not cleared, it is written before read
// within a frame. a stalled result holds its fields; new pixel requests are
// taken while the last result of the previous one waits
module edge_aware_2x_upscaler_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ea2x_pkg::AddrW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ea2x_pkg::PixW-1:0]    pixel_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ea2x_pkg::PixW-1:0]    out_value,
	output logic [ea2x_pkg::RowOW-1:0]   out_row,
	output logic [ea2x_pkg::ColOW-1:0]   out_col,
	output logic                         last_of_item,
	output logic                         frame_done
);
	import ea2x_pkg::*;

	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);

	cfg_t cfg;

	// effective geometry: zero means one, oversize saturates
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;

	// raster position of the next pixel
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic            last_col, last_row;

	// read stage
	logic            valid_s1;
	logic [PixW-1:0] e_s1;
	logic [CW-1:0]   col_s1;
	logic [RW-1:0]   row_s1;
	logic            last_col_s1, last_row_s1;

	// left neighbours in the current and previous source row
	logic [PixW-1:0] left_cur_q, left_prev_q;
	logic [PixW-1:0] above;

	logic            accept;
	logic            advance;
	logic            load_ok;
	pix_t            pix;

	ea2x_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		priority if (cfg.width == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.width);
		end
		priority if (cfg.height == '0) begin
			h_eff = HW'(1);
		end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.height);
		end
	end

	assign last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);

	// the read stage drains into the sequencer when it can take a new request
	assign advance  = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.geom_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line memory: the read at the column returns the row above, the same
	// edge stores the new pixel there
	ea2x_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk   (clk),
		.en    (accept),
		.addr  (col_q),
		.wdata (pixel_value),
		.rdata (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_s1        <= pixel_value;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cur_q  <= '0;
			left_prev_q <= '0;
		end else if (advance) begin
			left_cur_q  <= e_s1;
			left_prev_q <= above;
		end
	end

	assign pix.a        = left_prev_q;
	assign pix.b        = above;
	assign pix.d        = left_cur_q;
	assign pix.e        = e_s1;
	assign pix.last_row = last_row_s1;
	assign pix.last_col = last_col_s1;
	assign pix.r_nz     = (row_s1 != '0);
	assign pix.c_nz     = (col_s1 != '0);

	ea2x_emit #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.pix          (pix),
		.row          (row_s1),
		.col          (col_s1),
		.threshold    (cfg.threshold),
		.load_ok      (load_ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_item (last_of_item),
		.frame_done   (frame_done)
	);

endmodule

// ===== rtl/ea2x_cfg.sv =====
// apb register file of the upscaler
module ea2x_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ea2x_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output ea2x_pkg::cfg_t              cfg
);
	import ea2x_pkg::*;

	logic [ThrW-1:0] thr_q;
	logic [FwW-1:0]  fw_q;
	logic [FhW-1:0]  fh_q;
	logic            wr;
	logic [1:0]      idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			fw_q   <= WIDTH_RST;
			fh_q   <= HEIGHT_RST;
		end else begin
			if (wr) begin
				unique case (idx)
					REG_THRESHOLD: thr_q <= pwdata[ThrW-1:0];
					REG_WIDTH:     fw_q  <= pwdata[FwW-1:0];
					REG_HEIGHT:    fh_q  <= pwdata[FhW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESHOLD: prdata = {24'd0, thr_q};
			REG_WIDTH:     prdata = {20'd0, fw_q};
			REG_HEIGHT:    prdata = {19'd0, fh_q};
			default:       prdata = 32'd0;
		endcase
	end

	// geometry write clears the counters at the same edge as the register
	assign cfg.threshold = thr_q;
	assign cfg.width     = fw_q;
	assign cfg.height    = fh_q;
	assign cfg.geom_wr   = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT));

endmodule

// ===== rtl/ea2x_line_mem.sv =====
// one-line pixel memory, read-before-write, registered read
module ea2x_line_mem #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
	input  logic [ea2x_pkg::PixW-1:0]     wdata,
	output logic [ea2x_pkg::PixW-1:0]     rdata
);
	import ea2x_pkg::*;

	logic [PixW-1:0] mem [MAX_WIDTH];
	logic [PixW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ea2x_emit.sv =====
// result sequencer: walks the pending output pixels of one request
module ea2x_emit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  ea2x_pkg::pix_t                   pix,
	input  logic [$clog2(MAX_HEIGHT)-1:0]    row,
	input  logic [$clog2(MAX_WIDTH)-1:0]     col,
	input  logic [ea2x_pkg::ThrW-1:0]        threshold,
	output logic                             load_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ea2x_pkg::PixW-1:0]        out_value,
	output logic [ea2x_pkg::RowOW-1:0]       out_row,
	output logic [ea2x_pkg::ColOW-1:0]       out_col,
	output logic                             last_of_item,
	output logic                             frame_done
);
	import ea2x_pkg::*;

	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int CW = $clog2(MAX_WIDTH);

	logic [SlotN-1:0] mask_q;
	pix_t             pix_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;

	logic [SlotN-1:0] rest;
	logic [SlotN-1:0] new_mask;
	logic [3:0]       slot;
	logic [1:0]       anc;
	logic [1:0]       sub;
	logic [PixW-1:0]  p00, p01, p10, p11;
	logic [PixW-1:0]  dh, dv;
	logic             hedge, vedge;
	logic [PixW+1:0]  sum4;
	logic [PixW:0]    sumh, sumv;
	logic [RW-1:0]    y;
	logic [CW-1:0]    x;
	logic             up_left, up, left, self;

	assign rest         = mask_q & (mask_q - SlotN'(1));
	assign out_valid    = (mask_q != '0);
	assign last_of_item = (rest == '0);
	assign frame_done   = last_of_item && pix_q.last_row && pix_q.last_col;
	assign load_ok      = !out_valid || (last_of_item && out_ready);

	// lowest pending slot
	always_comb begin
		slot = 4'd0;
		for (int i = SlotN - 1; i >= 0; i--) begin
			if (mask_q[i]) slot = 4'(i);
		end
	end

	assign up_left = pix.r_nz && pix.c_nz;
	assign up      = pix.r_nz && pix.last_col;
	assign left    = pix.last_row && pix.c_nz;
	assign self    = pix.last_row && pix.last_col;

	// slot = anchor*4 + sub; sub 0 copy, 1 right, 2 down, 3 diagonal
	always_comb begin
		new_mask       = '0;
		new_mask[3:0]  = {4{up_left}};
		new_mask[4]    = up;
		new_mask[6]    = up;
		new_mask[8]    = left;
		new_mask[9]    = left;
		new_mask[12]   = self;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load && load_ok) begin
			mask_q <= new_mask;
		end else if (out_valid && out_ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			pix_q <= pix;
			row_q <= row;
			col_q <= col;
		end
	end

	assign anc = slot[3:2];
	assign sub = slot[1:0];

	always_comb begin
		p11 = pix_q.e;
		unique case (anc)
			ANC_UP_LEFT: begin
				p00 = pix_q.a; p01 = pix_q.b; p10 = pix_q.d;
			end
			ANC_UP: begin
				p00 = pix_q.b; p01 = pix_q.b; p10 = pix_q.e;
			end
			ANC_LEFT: begin
				p00 = pix_q.d; p01 = pix_q.e; p10 = pix_q.d;
			end
			default: begin
				p00 = pix_q.e; p01 = pix_q.e; p10 = pix_q.e;
			end
		endcase
	end

	assign dh    = (p01 > p00) ? p01 - p00 : p00 - p01;
	assign dv    = (p10 > p00) ? p10 - p00 : p00 - p10;
	assign hedge = dh > threshold;
	assign vedge = dv > threshold;
	assign sumh  = {1'b0, p00} + {1'b0, p01};
	assign sumv  = {1'b0, p00} + {1'b0, p10};
	assign sum4  = {2'b0, p00} + {2'b0, p01} + {2'b0, p10} + {2'b0, p11};

	always_comb begin
		unique case (sub)
			2'd0:    out_value = p00;
			2'd1:    out_value = hedge ? p01 : sumh[PixW:1];
			2'd2:    out_value = vedge ? p10 : sumv[PixW:1];
			default: out_value = (hedge || vedge) ? p11 : sum4[PixW+1:2];
		endcase
	end

	assign y = (anc == ANC_UP_LEFT || anc == ANC_UP) ? row_q - RW'(1) : row_q;
	assign x = (anc == ANC_UP_LEFT || anc == ANC_LEFT) ? col_q - CW'(1) : col_q;

	assign out_row = RowOW'({y, sub[1]});
	assign out_col = ColOW'({x, sub[0]});

endmodule
